@@ design/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared widths, register indexes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int ANGLE_W   = 32;
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 16;
    localparam int TOTAL_W   = 32;
    localparam int ACC_W     = 48;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_TBL_LEN     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam logic signed [ANGLE_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN     = 2'd1;

    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ design/ddo_mul.sv @@
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One 25 by 32 bit signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

@@ design/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// Computes cosine and sine in Q30 of a 32-bit binary angle, one rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ANGLE_W-1:0]        angle,
    output logic                      result_valid,
    output logic signed [ANGLE_W-1:0] cos_out,
    output logic signed [ANGLE_W-1:0] sin_out
);

    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic {C_IDLE, C_RUN} cordic_state_t;

    cordic_state_t             state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [ANGLE_W-1:0] x_reg;
    logic signed [ANGLE_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic                      flip_reg;
    logic                      valid_reg;
    logic signed [ANGLE_W-1:0] cos_reg;
    logic signed [ANGLE_W-1:0] sin_reg;

    logic [ANGLE_W-1:0]        angle_quarter;
    logic [ANGLE_W-1:0]        angle_folded;
    logic signed [ANGLE_W-1:0] x_shift;
    logic signed [ANGLE_W-1:0] y_shift;
    logic signed [ANGLE_W-1:0] atan_val;
    logic                      rot_pos;
    logic signed [ANGLE_W-1:0] x_next;
    logic signed [ANGLE_W-1:0] y_next;
    logic signed [ANGLE_W-1:0] z_next;

    // Angles in the back half-plane are turned by half a turn and the result negated.
    assign angle_quarter = angle + 32'h4000_0000;
    assign angle_folded  = angle_quarter[ANGLE_W-1] ? angle + 32'h8000_0000 : angle;

    assign x_shift  = x_reg >>> step_reg;
    assign y_shift  = y_reg >>> step_reg;
    assign atan_val = $signed(atan_turn(ATAN_IDX_W'(step_reg)));
    assign rot_pos  = ~z_reg[ANGLE_W-1];
    assign x_next   = rot_pos ? x_reg - y_shift : x_reg + y_shift;
    assign y_next   = rot_pos ? y_reg + x_shift : y_reg - x_shift;
    assign z_next   = rot_pos ? z_reg - atan_val : z_reg + atan_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            flip_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cos_reg   <= '0;
            sin_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= C_RUN;
                        step_reg  <= '0;
                        x_reg     <= INV_GAIN_Q30;
                        y_reg     <= '0;
                        z_reg     <= $signed(angle_folded);
                        flip_reg  <= angle_quarter[ANGLE_W-1];
                        valid_reg <= 1'b0;
                    end
                end
                C_RUN:
                begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1))
                    begin
                        state_reg <= C_IDLE;
                        valid_reg <= 1'b1;
                        cos_reg   <= flip_reg ? -x_next : x_next;
                        sin_reg   <= flip_reg ? -y_next : y_next;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign cos_out      = cos_reg;
    assign sin_out      = sin_reg;

endmodule

@@ design/differential_drive_odometry_core.sv @@
// ----------------------------------------------------------------------------
// Differential drive odometry core
// Dead reckoning for a two-wheel robot: tick totals, position and heading.
// ----------------------------------------------------------------------------
// Each item runs through the iterative CORDIC and six passes through the single shared
// multiplier; a new item is taken only after the last result is registered for output.
// The input is not ready while an item is in work.
// Reset clears the pose, the tick totals and both configuration registers.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // left_ticks, right_ticks
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [143:0]         m_tdata,    // position_x, position_y, heading_angle,
                                             // left_total, right_total
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SUM_W  = TICK_W + 1;
    localparam int P_W    = SUM_W + CFG_W;
    localparam int PL_W   = 20;
    localparam int SHR    = 31;
    localparam int WIDE_W = ACC_W + SHR - PL_W;
    localparam int OUT_W  = 2 * POS_W + HEAD_W + 2 * TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_P, S_MUL_H, S_HEAD, S_CWAIT,
        S_XH, S_XL, S_YH, S_YL, S_DY, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [CFG_W-1:0]          distance_reg;
    logic [CFG_W-1:0]          turn_reg;
    logic signed [TICK_W-1:0]  left_reg;
    logic signed [TICK_W-1:0]  right_reg;
    logic [TOTAL_W-1:0]        left_sum_reg;
    logic [TOTAL_W-1:0]        right_sum_reg;
    logic [ANGLE_W-1:0]        heading_reg;
    logic [ACC_W-1:0]          x_acc_reg;
    logic [ACC_W-1:0]          y_acc_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [MUL_P_W-1:0] t_reg;
    logic [ACC_W-1:0]          dx_reg;
    logic [ACC_W-1:0]          dy_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic signed [SUM_W-1:0]   tick_sum;
    logic signed [SUM_W-1:0]   tick_diff;
    logic signed [MUL_A_W-1:0] p_high;
    logic signed [MUL_A_W-1:0] p_low;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [WIDE_W-1:0]  wide_sum;
    logic [ACC_W-1:0]          y_acc_next;
    logic                      cordic_start;
    logic                      cordic_valid;
    logic signed [ANGLE_W-1:0] cos_val;
    logic signed [ANGLE_W-1:0] sin_val;
    logic                      in_fire;
    logic                      out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cordic_start = in_fire;

    assign tick_sum  = SUM_W'(left_reg) + SUM_W'(right_reg);
    assign tick_diff = SUM_W'(right_reg) - SUM_W'(left_reg);
    assign p_high    = MUL_A_W'(p_reg >>> PL_W);
    assign p_low     = $signed({{(MUL_A_W - PL_W){1'b0}}, p_reg[PL_W-1:0]});

    // The high partial product is weighted by 2^20, so the low one enters shifted down.
    assign wide_sum   = WIDE_W'(t_reg) + WIDE_W'(prod >>> PL_W);
    assign y_acc_next = y_acc_reg + dy_reg;

    always_comb
    begin
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = MUL_A_W'(tick_sum);
                mul_b = $signed({{(MUL_B_W - CFG_W){1'b0}}, distance_reg});
            end
            S_MUL_H:
            begin
                mul_a = MUL_A_W'(tick_diff);
                mul_b = $signed({{(MUL_B_W - CFG_W){1'b0}}, turn_reg});
            end
            S_XH:
            begin
                mul_a = p_high;
                mul_b = cos_val;
            end
            S_XL:
            begin
                mul_a = p_low;
                mul_b = cos_val;
            end
            S_YH:
            begin
                mul_a = p_high;
                mul_b = sin_val;
            end
            S_YL:
            begin
                mul_a = p_low;
                mul_b = sin_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cordic_start),
        .angle        (heading_reg),
        .result_valid (cordic_valid),
        .cos_out      (cos_val),
        .sin_out      (sin_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            distance_reg  <= '0;
            turn_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            heading_reg   <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            p_reg         <= '0;
            t_reg         <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DISTANCE: distance_reg <= cfg_data;
                    CFG_TURN:     turn_reg     <= cfg_data;
                    default:      ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        left_reg      <= $signed(s_tdata[TICK_W-1:0]);
                        right_reg     <= $signed(s_tdata[2*TICK_W-1:TICK_W]);
                        left_sum_reg  <= left_sum_reg
                                         + TOTAL_W'($signed(s_tdata[TICK_W-1:0]));
                        right_sum_reg <= right_sum_reg
                                         + TOTAL_W'($signed(s_tdata[2*TICK_W-1:TICK_W]));
                        state_reg     <= S_MUL_P;
                    end
                end
                S_MUL_P:
                begin
                    state_reg <= S_MUL_H;
                end
                S_MUL_H:
                begin
                    p_reg     <= prod[P_W-1:0];
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    // The CORDIC has already taken the old heading at acceptance.
                    heading_reg <= heading_reg + prod[ANGLE_W-1:0];
                    state_reg   <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    if (cordic_valid)
                    begin
                        state_reg <= S_XH;
                    end
                end
                S_XH:
                begin
                    state_reg <= S_XL;
                end
                S_XL:
                begin
                    t_reg     <= prod;
                    state_reg <= S_YH;
                end
                S_YH:
                begin
                    dx_reg    <= wide_sum[WIDE_W-1:SHR-PL_W];
                    state_reg <= S_YL;
                end
                S_YL:
                begin
                    x_acc_reg <= x_acc_reg + dx_reg;
                    t_reg     <= prod;
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    dy_reg    <= wide_sum[WIDE_W-1:SHR-PL_W];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        y_acc_reg    <= y_acc_next;
                        out_data_reg <= {right_sum_reg,
                                         left_sum_reg,
                                         heading_reg[ANGLE_W-1:ANGLE_W-HEAD_W],
                                         y_acc_next[ACC_W-1:ACC_W-POS_W],
                                         x_acc_reg[ACC_W-1:ACC_W-POS_W]};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ design/ddo_checker.sv @@
// ----------------------------------------------------------------------------
// Differential drive odometry port checker
// Watches the stream and configuration ports of the core over time.
// ----------------------------------------------------------------------------
module ddo_checker
    import ddo_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         cfg_ready
);

    // A result that is not taken stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // The core works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transaction");

    // No result can come out of the cycle right after an input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // The configuration channel does not stall while the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> cfg_ready)
        else $error("configuration channel stalled while idle");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
